/* design/bgam_pkg.sv */
// Shared types, constants and register codes for the battery gauge alert monitor.
`timescale 1ns / 1ps

package bgam_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ALERT_EN    = 3'd0;
  localparam logic [2:0] REG_LOW_PCT     = 3'd1;
  localparam logic [2:0] REG_VLOW_PCT    = 3'd2;
  localparam logic [2:0] REG_CRIT_PCT    = 3'd3;
  localparam logic [2:0] REG_MARGIN_PCT  = 3'd4;
  localparam logic [2:0] REG_ABSENT_MV   = 3'd5;
  localparam logic [2:0] REG_ABSENT_LIM  = 3'd6;

  // Register reset values
  localparam logic        RST_ALERT_EN   = 1'b0;
  localparam logic [6:0]  RST_LOW_PCT    = 7'd40;
  localparam logic [6:0]  RST_VLOW_PCT   = 7'd20;
  localparam logic [6:0]  RST_CRIT_PCT   = 7'd5;
  localparam logic [6:0]  RST_MARGIN_PCT = 7'd5;
  localparam logic [12:0] RST_ABSENT_MV  = 13'd2500;
  localparam logic [2:0]  RST_ABSENT_LIM = 3'd3;

  // Alert level codes
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_LOW  = 2'd1;
  localparam logic [1:0] LVL_VLOW = 2'd2;
  localparam logic [1:0] LVL_CRIT = 2'd3;

  // Divider scaling 57/47; 1/47 as (x * RECIP_47) >> RECIP_SHIFT, exact for 18-bit x
  localparam int unsigned SCALE_NUM   = 57;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [18:0] RECIP_47    = 19'd356963;

  // Li-ion curve breakpoints
  localparam logic [12:0] MV_FULL   = 13'd4200;
  localparam logic [12:0] MV_EMPTY  = 13'd3000;
  localparam logic [10:0] KNEE_OFS  = 11'd400;   // 3400 mV - 3000 mV
  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [6:0]  PCT_KNEE  = 7'd20;
  // floor(v / 10) as (v * DIV10_MUL) >> DIV10_SHIFT, exact below 1029
  localparam logic [7:0]  DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam logic [2:0] ABSENT_CNT_MAX = 3'd7;

  typedef struct packed {
    logic        alert_en;
    logic [6:0]  low_pct;
    logic [6:0]  vlow_pct;
    logic [6:0]  crit_pct;
    logic [6:0]  margin_pct;
    logic [12:0] absent_mv;
    logic [2:0]  absent_lim;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        busy;
    logic [6:0]  pct;
    logic [12:0] mv;
  } gauge_item_t;

endpackage

/* design/bgam_gauge.sv */
// Voltage scaling and percent interpolation pipeline (four stages, no state).
`timescale 1ns / 1ps

module bgam_gauge
  import bgam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [11:0] in_adc,
  input  logic        in_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output gauge_item_t out_item
);

  // stage a: raw word
  logic        va;
  logic        a_action, a_busy;
  logic [11:0] a_adc;
  // stage b: divider * 57
  logic        vb;
  logic        b_action, b_busy;
  logic [17:0] b_prod;
  // stage c: battery mV
  logic        vc;
  logic        c_action, c_busy;
  logic [12:0] c_mv;
  // stage d: percent
  logic        vd;
  gauge_item_t d_item;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic [17:0] prod;
  logic [36:0] recip_prod;
  logic [12:0] mv;
  logic [10:0] ofs;
  logic [9:0]  div_arg;
  logic [6:0]  div_base;
  logic [17:0] div_prod;
  logic [6:0]  pct;

  assign rdy_d    = !vd | out_ready;
  assign rdy_c    = !vc | rdy_d;
  assign rdy_b    = !vb | rdy_c;
  assign rdy_a    = !va | rdy_b;
  assign in_ready = rdy_a;

  assign prod       = 18'({6'b0, a_adc} * 18'(SCALE_NUM));
  assign recip_prod = {19'b0, b_prod} * {18'b0, RECIP_47};
  assign mv         = recip_prod[RECIP_SHIFT +: 13];

  // Above the knee every segment is 100 mV per 10 %, below it 200 mV per 10 %.
  always_comb begin
    ofs = 11'(c_mv - MV_EMPTY);
    if (ofs <= KNEE_OFS) begin
      div_arg  = ofs[10:1];
      div_base = '0;
    end else begin
      div_arg  = 10'(ofs - KNEE_OFS);
      div_base = PCT_KNEE;
    end
    div_prod = {8'b0, div_arg} * {10'b0, DIV10_MUL};
    if (c_mv >= MV_FULL)       pct = PCT_FULL;
    else if (c_mv <= MV_EMPTY) pct = '0;
    else                       pct = div_base + div_prod[DIV10_SHIFT +: 7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_action <= in_action;
      a_busy   <= in_busy;
      a_adc    <= in_adc;
    end
    if (rdy_b) begin
      b_action <= a_action;
      b_busy   <= a_busy;
      b_prod   <= prod;
    end
    if (rdy_c) begin
      c_action <= b_action;
      c_busy   <= b_busy;
      c_mv     <= mv;
    end
    if (rdy_d) begin
      d_item.action <= c_action;
      d_item.busy   <= c_busy;
      d_item.mv     <= c_mv;
      d_item.pct    <= pct;
    end
  end

  assign out_valid = vd;
  assign out_item  = d_item;

endmodule

/* design/bgam_alert.sv */
// Absence counting, alert levels with re-arm, deferral, and the result register.
`timescale 1ns / 1ps

module bgam_alert
  import bgam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  gauge_item_t in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_data
);

  logic [2:0]  done, done_next;
  logic [1:0]  pend, pend_next;
  logic [2:0]  cnt, cnt_next;
  logic        absent, absent_next;
  logic [6:0]  last_pct, last_pct_next;
  logic [12:0] last_mv, last_mv_next;
  logic        notify_next;
  logic [1:0]  fired;
  logic [6:0]  lvl [3];
  logic        load;

  logic        out_notify, out_absent;
  logic [1:0]  out_pend;
  logic [6:0]  out_pct;
  logic [12:0] out_mv;

  assign in_ready = !out_valid | out_ready;
  assign load     = in_valid & in_ready;

  assign lvl[0] = cfg.low_pct;
  assign lvl[1] = cfg.vlow_pct;
  assign lvl[2] = cfg.crit_pct;

  always_comb begin
    done_next     = done;
    pend_next     = pend;
    cnt_next      = cnt;
    absent_next   = absent;
    last_pct_next = last_pct;
    last_mv_next  = last_mv;
    notify_next   = 1'b0;
    fired         = LVL_NONE;
    if (in_item.action) begin
      pend_next = LVL_NONE;
    end else begin
      last_pct_next = in_item.pct;
      last_mv_next  = in_item.mv;
      if (in_item.mv < cfg.absent_mv) begin
        if (cnt != ABSENT_CNT_MAX) cnt_next = cnt + 3'd1;
        if (cnt_next >= cfg.absent_lim) absent_next = 1'b1;
      end else begin
        cnt_next    = '0;
        absent_next = 1'b0;
      end
      if (cfg.alert_en && !absent_next) begin
        if (pend != LVL_NONE && !in_item.busy) begin
          // flush the deferred alert; it stays pending until played
          done_next[2'(pend - 2'd1)] = 1'b1;
          notify_next = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (in_item.pct <= lvl[k] && !done[k]) begin
              fired = 2'(k + 1);
              if (!in_item.busy) begin
                done_next[k] = 1'b1;
                notify_next  = 1'b1;
              end
            end else if ({1'b0, in_item.pct} > ({1'b0, lvl[k]} + {1'b0, cfg.margin_pct})) begin
              done_next[k] = 1'b0;
            end
          end
          // pend may already be set while busy; keep the higher of it and the highest fired level
          if (fired > pend) pend_next = fired;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      pend      <= LVL_NONE;
      cnt       <= '0;
      absent    <= 1'b0;
      last_pct  <= '0;
      last_mv   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (load) begin
        done     <= done_next;
        pend     <= pend_next;
        cnt      <= cnt_next;
        absent   <= absent_next;
        last_pct <= last_pct_next;
        last_mv  <= last_mv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pct    <= last_pct_next;
      out_mv     <= last_mv_next;
      out_absent <= absent_next;
      out_notify <= notify_next;
      out_pend   <= pend_next;
    end
  end

  assign out_data = {out_pend, out_notify, out_absent, out_mv, out_pct};

  a_notify_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_notify |-> out_pend != LVL_NONE)
    else $error("notify without a pending level");

  a_notify_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_notify |-> !out_absent)
    else $error("notify while battery absent");

  a_played_clears: assert property (@(posedge clk) disable iff (rst)
    load && in_item.action |=> pend == LVL_NONE)
    else $error("played word did not clear pending level");

  a_absent_count: assert property (@(posedge clk) disable iff (rst)
    absent |-> cnt != 3'd0)
    else $error("absent state with zero absent count");

endmodule

/* design/battery_gauge_alert_monitor_top.sv */
// Battery gauge alert monitor: top level with configuration registers.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tuser action; s_tdata divider_mv, playback_busy
//  m_*       out  m_tvalid/m_tready   m_tdata pct, mv, absent, notify, pending
//  APB       in   psel/penable/pready register write/read, 7 registers at 4*i
//
// One word per cycle sustained while m_tready stays high; a taken word passes the input
// register and three gauge stages for the 57/47 scaling and interpolation, then
// the alert stage that updates state and loads the result register.
// Reset clears the pipeline, alert state and registers to their defaults.
// A stalled result holds the result register; earlier stages keep filling
// until full, then s_tready drops.
`timescale 1ns / 1ps

module battery_gauge_alert_monitor_top
  import bgam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] divider_mv, [12] playback_busy, rest zero
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] charge_pct, [19:7] battery_mv, [20] absent_flag,
                                 // [21] notify, [23:22] pending_alert
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        g_valid, g_ready;
  gauge_item_t g_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alert_en   <= RST_ALERT_EN;
      cfg.low_pct    <= RST_LOW_PCT;
      cfg.vlow_pct   <= RST_VLOW_PCT;
      cfg.crit_pct   <= RST_CRIT_PCT;
      cfg.margin_pct <= RST_MARGIN_PCT;
      cfg.absent_mv  <= RST_ABSENT_MV;
      cfg.absent_lim <= RST_ABSENT_LIM;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ALERT_EN:   cfg.alert_en   <= pwdata[0];
        REG_LOW_PCT:    cfg.low_pct    <= pwdata[6:0];
        REG_VLOW_PCT:   cfg.vlow_pct   <= pwdata[6:0];
        REG_CRIT_PCT:   cfg.crit_pct   <= pwdata[6:0];
        REG_MARGIN_PCT: cfg.margin_pct <= pwdata[6:0];
        REG_ABSENT_MV:  cfg.absent_mv  <= pwdata[12:0];
        REG_ABSENT_LIM: cfg.absent_lim <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALERT_EN:   prdata = {31'b0, cfg.alert_en};
      REG_LOW_PCT:    prdata = {25'b0, cfg.low_pct};
      REG_VLOW_PCT:   prdata = {25'b0, cfg.vlow_pct};
      REG_CRIT_PCT:   prdata = {25'b0, cfg.crit_pct};
      REG_MARGIN_PCT: prdata = {25'b0, cfg.margin_pct};
      REG_ABSENT_MV:  prdata = {19'b0, cfg.absent_mv};
      REG_ABSENT_LIM: prdata = {29'b0, cfg.absent_lim};
      default:        prdata = '0;
    endcase
  end

  bgam_gauge u_gauge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_adc    (s_tdata[11:0]),
    .in_busy   (s_tdata[12]),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_item  (g_item)
  );

  bgam_alert u_alert (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_item   (g_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the battery gauge alert monitor: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench;
  import bgam_pkg::*;

  localparam logic ACT_POLL   = 1'b0;
  localparam logic ACT_PLAYED = 1'b1;
  localparam int unsigned DIV_NUM = 57;
  localparam int unsigned DIV_DEN = 47;
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 242;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct {
    logic        action;
    logic [11:0] adc;
    logic        busy;
  } poll_word_t;

  typedef struct {
    logic [6:0]  pct;
    logic [12:0] mv;
    logic        absent;
    logic        notify;
    logic [1:0]  pend;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  battery_gauge_alert_monitor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Li-ion discharge curve
  int unsigned curve_mv  [0:10] = '{4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500,
                                    3400, 3200, 3000};
  int unsigned curve_pct [0:10] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 0};

  // Gauge model state and register shadow
  cfg_t cfg = '{RST_ALERT_EN, RST_LOW_PCT, RST_VLOW_PCT, RST_CRIT_PCT, RST_MARGIN_PCT,
                RST_ABSENT_MV, RST_ABSENT_LIM};
  logic        done_lvl [LVL_LOW:LVL_CRIT] = '{1'b0, 1'b0, 1'b0};
  logic [1:0]  pend_lvl = LVL_NONE;
  logic [2:0]  absent_cnt = '0;
  logic        absent_now = 1'b0;
  logic [6:0]  last_pct = '0;
  logic [12:0] last_mv = '0;

  poll_word_t poll_words[$];
  reading_t   expected_readings[$];
  poll_word_t in_flight;
  bit         no_gaps = 1'b0;
  int         n_queued = 0;
  int         n_checked = 0;
  int         n_errors = 0;
  int         n_notify = 0;
  int         n_absent = 0;
  int         n_played = 0;
  int         n_settings = 0;

  function automatic reading_t gauge_predict(input poll_word_t w);
    reading_t    r;
    int unsigned mv;
    int unsigned pct;
    logic [6:0]  lvl_pct [LVL_LOW:LVL_CRIT];
    lvl_pct[LVL_LOW]  = cfg.low_pct;
    lvl_pct[LVL_VLOW] = cfg.vlow_pct;
    lvl_pct[LVL_CRIT] = cfg.crit_pct;
    r.notify = 1'b0;
    if (w.action == ACT_PLAYED) begin
      pend_lvl = LVL_NONE;
    end else begin
      mv = w.adc * DIV_NUM / DIV_DEN;
      pct = 0;
      if (mv >= curve_mv[0]) begin
        pct = 100;
      end else if (mv > curve_mv[10]) begin
        for (int i = 0; i < 10; i++)
          if (mv <= curve_mv[i] && mv > curve_mv[i+1])
            pct = curve_pct[i+1] + (mv - curve_mv[i+1]) * (curve_pct[i] - curve_pct[i+1])
                  / (curve_mv[i] - curve_mv[i+1]);
      end
      last_mv  = mv[12:0];
      last_pct = pct[6:0];
      if (mv < cfg.absent_mv) begin
        if (absent_cnt < ABSENT_CNT_MAX) absent_cnt++;
        if (absent_cnt >= cfg.absent_lim) absent_now = 1'b1;
      end else begin
        absent_cnt = '0;
        absent_now = 1'b0;
      end
      if (cfg.alert_en && !absent_now) begin
        if (pend_lvl != LVL_NONE && !w.busy) begin
          // flush of a deferred alert; thresholds skipped this poll
          done_lvl[pend_lvl] = 1'b1;
          r.notify = 1'b1;
        end else begin
          for (int c = LVL_LOW; c <= LVL_CRIT; c++) begin
            if (pct <= lvl_pct[c] && !done_lvl[c]) begin
              if (!w.busy) begin
                done_lvl[c] = 1'b1;
                pend_lvl = 2'(c);
                r.notify = 1'b1;
              end else if (pend_lvl == LVL_NONE || c > pend_lvl) begin
                pend_lvl = 2'(c);
              end
            end else if (pct > lvl_pct[c] + cfg.margin_pct) begin
              done_lvl[c] = 1'b0;
            end
          end
        end
      end
    end
    r.pct    = last_pct;
    r.mv     = last_mv;
    r.absent = absent_now;
    r.pend   = pend_lvl;
    return r;
  endfunction

  // Driver: one word in flight, predicted when accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_readings.push_back(gauge_predict(in_flight));
      if (!s_tvalid || s_tready) begin
        if (poll_words.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          in_flight = poll_words.pop_front();
          s_tdata  <= {3'b000, in_flight.busy, in_flight.adc};
          s_tuser  <= in_flight.action;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int e, input int a);
    if (e != a) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  // Monitor
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_readings.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t ns: unexpected word, expected none actual 0x%06h", $time, m_tdata);
        end else begin
          exp_r = expected_readings.pop_front();
          check_field("charge_pct", exp_r.pct, m_tdata[6:0]);
          check_field("battery_mv", exp_r.mv, m_tdata[19:7]);
          check_field("absent_flag", exp_r.absent, m_tdata[20]);
          check_field("notify", exp_r.notify, m_tdata[21]);
          check_field("pending_alert", exp_r.pend, m_tdata[23:22]);
          n_notify += exp_r.notify;
          n_absent += exp_r.absent;
          n_checked++;
        end
      end
      m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALERT_EN:   cfg.alert_en   = val[0];
      REG_LOW_PCT:    cfg.low_pct    = val[6:0];
      REG_VLOW_PCT:   cfg.vlow_pct   = val[6:0];
      REG_CRIT_PCT:   cfg.crit_pct   = val[6:0];
      REG_MARGIN_PCT: cfg.margin_pct = val[6:0];
      REG_ABSENT_MV:  cfg.absent_mv  = val[12:0];
      REG_ABSENT_LIM: cfg.absent_lim = val[2:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int en, input int low, input int vlow, input int crit,
                               input int margin, input int thr, input int lim);
    write_reg(REG_ALERT_EN, en);
    write_reg(REG_LOW_PCT, low);
    write_reg(REG_VLOW_PCT, vlow);
    write_reg(REG_CRIT_PCT, crit);
    write_reg(REG_MARGIN_PCT, margin);
    write_reg(REG_ABSENT_MV, thr);
    write_reg(REG_ABSENT_LIM, lim);
    n_settings++;
  endtask

  task automatic queue_word(input logic act, input int unsigned adc, input logic busy);
    poll_word_t w;
    w.action = act;
    w.adc    = adc[11:0];
    w.busy   = busy;
    poll_words.push_back(w);
    n_queued++;
    if (act == ACT_PLAYED) n_played++;
  endtask

  // Sender holds off until every reading is back, then lets the pipeline settle
  task automatic drain();
    wait (n_checked == n_queued);
    repeat (8) @(posedge clk);
  endtask

  function automatic int unsigned adc_for(input int unsigned mv);
    return (mv * DIV_DEN + DIV_NUM - 1) / DIV_NUM;
  endfunction

  initial begin
    int unsigned ramp;
    int unsigned r;
    int low, vlow;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: alerts off, field extremes
    queue_word(ACT_POLL, 0, 1'b0);
    queue_word(ACT_POLL, 4095, 1'b1);
    queue_word(ACT_PLAYED, 4095, 1'b1);
    drain();

    // Discharge walk: immediate fire, deferral, highest-pending, flush, re-arm, absence
    load_settings(1, 40, 20, 5, 5, 2500, 3);
    queue_word(ACT_POLL, adc_for(4200), 1'b0);
    queue_word(ACT_POLL, adc_for(3600), 1'b0);
    queue_word(ACT_PLAYED, 0, 1'b0);
    queue_word(ACT_POLL, adc_for(3400), 1'b1);
    queue_word(ACT_POLL, adc_for(3000), 1'b1);
    queue_word(ACT_POLL, adc_for(3000), 1'b1);
    queue_word(ACT_POLL, adc_for(3000), 1'b0);
    queue_word(ACT_PLAYED, 0, 1'b0);
    queue_word(ACT_POLL, adc_for(3000), 1'b0);
    queue_word(ACT_PLAYED, 0, 1'b1);
    queue_word(ACT_POLL, 4095, 1'b0);
    queue_word(ACT_POLL, adc_for(2000), 1'b0);
    queue_word(ACT_POLL, adc_for(2000), 1'b0);
    queue_word(ACT_POLL, adc_for(2000), 1'b0);
    queue_word(ACT_POLL, 4095, 1'b1);
    queue_word(ACT_PLAYED, 0, 1'b0);
    queue_word(ACT_POLL, 3463, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      no_gaps = (p == 2);
      case (p)
        0: load_settings(1, 0, 0, 0, 0, 0, 1);
        1: load_settings(1, 100, 100, 100, 100, 5000, 7);
        // levels past full scale and a zero absent limit
        3: load_settings(1, 127, 127, 127, $urandom_range(20), 2500, 0);
        5: load_settings(0, 40, 20, 5, 5, 2500, 3);
        default: begin
          low  = $urandom_range(100);
          vlow = $urandom_range(low);
          load_settings(1, low, vlow, $urandom_range(vlow), $urandom_range(20),
                        $urandom_range(2000, 3000), $urandom_range(1, 7));
        end
      endcase
      ramp = $urandom_range(2500, 3600);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        r = $urandom_range(99);
        if (r < 12) begin
          queue_word(ACT_PLAYED, $urandom_range(4095), 1'($urandom_range(1)));
        end else if (r < 20) begin
          queue_word(ACT_POLL, $urandom_range(4095), 1'($urandom_range(1)));
        end else if (r < 24) begin
          queue_word(ACT_POLL, $urandom_range(2100), 1'($urandom_range(1)));
        end else begin
          // slow discharge with occasional recharge jumps
          ramp = ramp - $urandom_range(25);
          if (ramp < 2400 || $urandom_range(49) == 0) ramp = $urandom_range(2500, 3600);
          queue_word(ACT_POLL, ramp, $urandom_range(99) < 35);
        end
      end
      drain();
    end

    $display("Run: %0d words (%0d played acks) over %0d register settings,", n_queued,
             n_played, n_settings);
    $display("     %0d alert requests and %0d absent readings checked.", n_notify, n_absent);
    if (n_errors == 0 && expected_readings.size() == 0) begin
      $display("[battery_gauge_alert_monitor_top] OK");
    end else begin
      $display("[battery_gauge_alert_monitor_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d of %0d readings checked", n_checked, n_queued);
    $display("[battery_gauge_alert_monitor_top] ERROR");
    $finish;
  end

endmodule
